// File: sv/stpw_pkg.sv
package stpw_pkg;

	localparam int unsigned PoolPagesDef = 64;

	localparam int unsigned IdxW   = 9;
	localparam int unsigned VpnW   = 27;
	localparam int unsigned PpnW   = 44;
	localparam int unsigned CntW   = 21;
	localparam int unsigned PermW  = 10;
	localparam int unsigned EntryW = PpnW + PermW;
	localparam int unsigned StW    = 2;

	localparam int unsigned ValidBit = 0;
	localparam logic [PermW-1:0] ValidMask = PermW'(1 << ValidBit);

	localparam logic [PpnW-1:0] PoolBaseRst = 44'd524288;

	typedef enum logic [StW-1:0] {
		ST_OK         = 2'd0,
		ST_POOL_EMPTY = 2'd1,
		ST_NO_PATH    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		LVL_2,
		LVL_1,
		LVL_0
	} lvl_t;

	typedef enum logic [3:0] {
		S_CLR_ROOT,
		S_IDLE,
		S_START,
		S_RD2,
		S_EV2,
		S_CLR_PG2,
		S_RD1,
		S_EV1,
		S_CLR_PG1,
		S_RD0,
		S_EV0,
		S_FIN
	} state_t;

	typedef struct packed {
		logic    load_item;
		logic    rd_en;
		lvl_t    rd_lvl;
		logic    follow;
		logic    alloc;
		logic    clr_wr;
		logic    leaf_wr;
		logic    cap_leaf;
		logic    set_st;
		status_t st_code;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic entry_valid;
		logic ptr_ok;
		logic pool_full;
		logic clr_last;
		logic all_done;
		logic last_page;
		logic out_free;
	} sts_t;

endpackage

// File: sv/stpw_ram.sv
module stpw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/stpw_dp.sv
module stpw_dp
	import stpw_pkg::*;
#(
	parameter int unsigned POOL_PAGES = PoolPagesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_wr_en,
	input  logic [PpnW-1:0]   cfg_wr_data,
	input  logic              op,
	input  logic [VpnW-1:0]   virt_page,
	input  logic [PpnW-1:0]   phys_page,
	input  logic [CntW-1:0]   page_count,
	input  logic [PermW-1:0]  perm_bits,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [StW-1:0]    status,
	output logic              remap_seen,
	output logic [CntW-1:0]   pages_done,
	output logic [EntryW-1:0] leaf_entry
);

	localparam int unsigned PW    = $clog2(POOL_PAGES);
	localparam int unsigned NW    = $clog2(POOL_PAGES + 1);
	localparam int unsigned Depth = POOL_PAGES << IdxW;
	localparam int unsigned AW    = PW + IdxW;

	// control registers
	logic [PpnW-1:0] base_q;
	logic [NW-1:0]   next_free_q;
	logic [PW-1:0]   page_q;
	logic [IdxW-1:0] cnt_q;
	logic            out_valid_q;

	// item registers
	logic              op_q;
	logic [VpnW-1:0]   vpn_q;
	logic [PpnW-1:0]   ppn_q;
	logic [CntW-1:0]   count_q;
	logic [PermW-1:0]  perm_q;
	logic [CntW-1:0]   done_q;
	logic              remap_q;
	status_t           status_q;
	logic [EntryW-1:0] leaf_q;
	logic [AW-1:0]     addr_q;

	// output beat
	status_t           st_out_q;
	logic              remap_out_q;
	logic [CntW-1:0]   done_out_q;
	logic [EntryW-1:0] leaf_out_q;

	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [EntryW-1:0] wr_data;
	logic              wr_en;
	logic [EntryW-1:0] rd_data;
	logic [PpnW-1:0]   ptr_page;
	logic [PW-1:0]     new_page;
	logic [EntryW-1:0] link_entry;
	logic [EntryW-1:0] leaf_new;

	assign ptr_page   = rd_data[EntryW-1:PermW] - base_q;
	assign new_page   = next_free_q[PW-1:0];
	assign link_entry = {base_q + {{(PpnW-PW){1'b0}}, new_page}, ValidMask};
	assign leaf_new   = {ppn_q, perm_q | ValidMask};

	always_comb begin
		case (cmd.rd_lvl)
			LVL_2:   rd_addr = {{PW{1'b0}}, vpn_q[3*IdxW-1:2*IdxW]};
			LVL_1:   rd_addr = {page_q, vpn_q[2*IdxW-1:IdxW]};
			LVL_0:   rd_addr = {page_q, vpn_q[IdxW-1:0]};
			default: rd_addr = {page_q, vpn_q[IdxW-1:0]};
		endcase
	end

	always_comb begin
		wr_en   = cmd.alloc | cmd.leaf_wr | cmd.clr_wr;
		wr_addr = addr_q;
		wr_data = '0;
		if (cmd.clr_wr) begin
			wr_addr = {page_q, cnt_q};
		end
		if (cmd.alloc) begin
			wr_data = link_entry;
		end
		if (cmd.leaf_wr) begin
			wr_data = leaf_new;
		end
	end

	stpw_ram #(
		.WIDTH (EntryW),
		.DEPTH (Depth)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= PoolBaseRst;
			next_free_q <= NW'(1);
			page_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (cmd.follow) begin
				page_q <= ptr_page[PW-1:0];
			end
			if (cmd.alloc) begin
				page_q      <= new_page;
				next_free_q <= next_free_q + NW'(1);
			end
			if (cmd.clr_wr) begin
				cnt_q <= cnt_q + IdxW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q     <= op;
			vpn_q    <= virt_page;
			ppn_q    <= phys_page;
			count_q  <= page_count;
			perm_q   <= perm_bits;
			done_q   <= '0;
			remap_q  <= 1'b0;
			status_q <= ST_OK;
			leaf_q   <= '0;
		end
		if (cmd.rd_en) begin
			addr_q <= rd_addr;
		end
		if (cmd.leaf_wr) begin
			remap_q <= remap_q | rd_data[ValidBit];
			done_q  <= done_q + CntW'(1);
			vpn_q   <= vpn_q + VpnW'(1);
			ppn_q   <= ppn_q + PpnW'(1);
		end
		if (cmd.cap_leaf) begin
			leaf_q <= rd_data;
		end
		if (cmd.set_st) begin
			status_q <= cmd.st_code;
		end
		if (cmd.out_load) begin
			st_out_q    <= status_q;
			remap_out_q <= remap_q;
			done_out_q  <= done_q;
			leaf_out_q  <= leaf_q;
		end
	end

	always_comb begin
		sts.is_lookup   = op_q;
		sts.entry_valid = rd_data[ValidBit];
		sts.ptr_ok      = ptr_page < {{(PpnW-NW){1'b0}}, next_free_q};
		sts.pool_full   = next_free_q >= NW'(POOL_PAGES);
		sts.clr_last    = &cnt_q;
		sts.all_done    = done_q == count_q;
		sts.last_page   = (done_q + CntW'(1)) == count_q;
		sts.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid  = out_valid_q;
	assign status     = st_out_q;
	assign remap_seen = remap_out_q;
	assign pages_done = done_out_q;
	assign leaf_entry = leaf_out_q;

endmodule

// File: sv/stpw_ctrl.sv
module stpw_ctrl
	import stpw_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  sts_t   sts,
	output cmd_t   cmd,
	output state_t state
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_ROOT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR_ROOT: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_START;
			end
			S_START: begin
				if (!sts.is_lookup && sts.all_done) state_d = S_FIN;
				else state_d = S_RD2;
			end
			S_RD2: state_d = S_EV2;
			S_EV2: begin
				if (sts.entry_valid) begin
					state_d = sts.ptr_ok ? S_RD1 : S_FIN;
				end else if (sts.is_lookup || sts.pool_full) begin
					state_d = S_FIN;
				end else begin
					state_d = S_CLR_PG2;
				end
			end
			S_CLR_PG2: begin
				if (sts.clr_last) state_d = S_RD1;
			end
			S_RD1: state_d = S_EV1;
			S_EV1: begin
				if (sts.entry_valid) begin
					state_d = sts.ptr_ok ? S_RD0 : S_FIN;
				end else if (sts.is_lookup || sts.pool_full) begin
					state_d = S_FIN;
				end else begin
					state_d = S_CLR_PG1;
				end
			end
			S_CLR_PG1: begin
				if (sts.clr_last) state_d = S_RD0;
			end
			S_RD0: state_d = S_EV0;
			S_EV0: begin
				if (sts.is_lookup || sts.last_page) state_d = S_FIN;
				else state_d = S_RD2;
			end
			S_FIN: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLR_ROOT;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.rd_lvl  = LVL_2;
		cmd.st_code = ST_OK;
		case (state_q)
			S_CLR_ROOT, S_CLR_PG2, S_CLR_PG1: cmd.clr_wr = 1'b1;
			S_IDLE: cmd.load_item = in_valid;
			S_RD2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_lvl = LVL_2;
			end
			S_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_lvl = LVL_1;
			end
			S_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_lvl = LVL_0;
			end
			S_EV2, S_EV1: begin
				if (sts.entry_valid) begin
					if (sts.ptr_ok) begin
						cmd.follow = 1'b1;
					end else begin
						cmd.set_st  = 1'b1;
						cmd.st_code = ST_NO_PATH;
					end
				end else if (sts.is_lookup) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ST_NO_PATH;
				end else if (sts.pool_full) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ST_POOL_EMPTY;
				end else begin
					cmd.alloc = 1'b1;
				end
			end
			S_EV0: begin
				if (sts.is_lookup) cmd.cap_leaf = 1'b1;
				else cmd.leaf_wr = 1'b1;
			end
			S_FIN: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign state    = state_q;

endmodule

// File: sv/sv39_page_table_map_walk_top.sv
// Lookup: start, then read and evaluate at levels 2, 1 and 0 in turn, then finish loads the result beat.
// Map: per page the same walk, and each fresh table page is first cleared, all 512 entries.
// One item at a time; each page takes three dependent reads of the entry store, and the
// next item is taken once its result sits in the output register.
// After reset all 512 entries of the root table page are swept to zero; no beat is taken
// meanwhile, configuration writes are. Pool base resets to page 524288.
module sv39_page_table_map_walk_top
	import stpw_pkg::*;
#(
	parameter int unsigned POOL_PAGES = PoolPagesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [PpnW-1:0]   cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [VpnW-1:0]   virt_page,
	input  logic [PpnW-1:0]   phys_page,
	input  logic [CntW-1:0]   page_count,
	input  logic [PermW-1:0]  perm_bits,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [StW-1:0]    status,
	output logic              remap_seen,
	output logic [CntW-1:0]   pages_done,
	output logic [EntryW-1:0] leaf_entry
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	stpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	stpw_dp #(
		.POOL_PAGES (POOL_PAGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op          (op),
		.virt_page   (virt_page),
		.phys_page   (phys_page),
		.page_count  (page_count),
		.perm_bits   (perm_bits),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.remap_seen  (remap_seen),
		.pages_done  (pages_done),
		.leaf_entry  (leaf_entry)
	);

	// an accepted beat must close the input side until its result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

	// store reads and writes never share a cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !(cmd.alloc || cmd.leaf_wr || cmd.clr_wr))
		else $error("store read and write collide");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.alloc, cmd.leaf_wr, cmd.clr_wr}))
		else $error("several store writes at once");

	// a result is loaded only from the finish state, and the input side reopens next
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (state == S_FIN) ##1 !in_stall)
		else $error("result loaded out of sequence");

endmodule
